[design/tuc_pkg.sv]
`default_nettype none

package tuc_pkg;

    localparam int DEF_ENTRIES   = 64;
    localparam int DEF_ATOM_BITS = 10;

    // fixed field widths on the ports
    localparam int FLD_ATOM_W  = 10;
    localparam int FLD_SLOT_W  = 6;
    localparam int FLD_COUNT_W = 7;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_MERGE = 2'd2;

    localparam logic [1:0] KIND_PAIR   = 2'd0;
    localparam logic [1:0] KIND_TRIPLE = 2'd1;
    localparam logic [1:0] KIND_QUAD   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_DONE
    } t_state;

    // control bits of the search token that walks the cell chain
    typedef struct packed {
        logic       valid;
        logic       wr;
        logic       found;
        logic [1:0] kind;
    } t_ctl;

endpackage

`default_nettype wire

[design/tuc_cell.sv]
`default_nettype none

module tuc_cell #(
    parameter int ENTRIES   = tuc_pkg::DEF_ENTRIES,
    parameter int ATOM_BITS = tuc_pkg::DEF_ATOM_BITS,
    parameter int IDX       = 0
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  tuc_pkg::t_ctl                 i_ctl,
    input  wire  [4*ATOM_BITS-1:0]              i_tup,
    input  wire  [$clog2(ENTRIES+1)-1:0]        i_lod,
    input  wire  [$clog2(ENTRIES+1)-1:0]        i_tot,
    input  wire  [$clog2(ENTRIES)-1:0]          i_slot,
    output tuc_pkg::t_ctl                       o_ctl,
    output logic [4*ATOM_BITS-1:0]              o_tup,
    output logic [$clog2(ENTRIES+1)-1:0]        o_lod,
    output logic [$clog2(ENTRIES+1)-1:0]        o_tot,
    output logic [$clog2(ENTRIES)-1:0]          o_slot
);

    localparam int AW    = ATOM_BITS;
    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int IDX_W = $clog2(ENTRIES);

    logic [AW-1:0] a, b, c, d;
    logic [AW-1:0] r_p0, r_p1;
    logic [AW-1:0] r_t0, r_t1, r_t2;
    logic [AW-1:0] r_q0, r_q1, r_q2, r_q3;
    logic          match;
    logic          hit;
    logic          wr_here;

    tuc_pkg::t_ctl         r_ctl, n_ctl;
    logic [4*AW-1:0]       r_tup;
    logic [CNT_W-1:0]      r_lod, r_tot;
    logic [IDX_W-1:0]      r_slot, n_slot;

    assign a = i_tup[AW-1:0];
    assign b = i_tup[2*AW-1:AW];
    assign c = i_tup[3*AW-1:2*AW];
    assign d = i_tup[4*AW-1:3*AW];

    always_comb begin
        case (i_ctl.kind)
            tuc_pkg::KIND_PAIR: begin
                match = (a == r_p0 && b == r_p1) || (a == r_p1 && b == r_p0);
            end
            tuc_pkg::KIND_TRIPLE: begin
                match = (b == r_t1) &&
                        ((a == r_t0 && c == r_t2) || (a == r_t2 && c == r_t0));
            end
            tuc_pkg::KIND_QUAD: begin
                match = (a == r_q0 && b == r_q1 && c == r_q2 && d == r_q3) ||
                        (a == r_q3 && b == r_q2 && c == r_q1 && d == r_q0);
            end
            default: begin
                match = 1'b0;
            end
        endcase
    end

    // only first-set entries take part in the search
    assign hit     = i_ctl.valid && !i_ctl.found && (CNT_W'(IDX) < i_lod) && match;
    assign wr_here = i_ctl.valid && i_ctl.wr && !i_ctl.found && (i_tot == CNT_W'(IDX));

    always_comb begin
        n_ctl       = i_ctl;
        n_ctl.found = i_ctl.found | hit;
        n_slot      = hit ? IDX_W'(IDX) : i_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tup  <= i_tup;
        r_lod  <= i_lod;
        r_tot  <= i_tot;
        r_slot <= n_slot;
        if (wr_here && i_ctl.kind == tuc_pkg::KIND_PAIR) begin
            r_p0 <= a;
            r_p1 <= b;
        end
        if (wr_here && i_ctl.kind == tuc_pkg::KIND_TRIPLE) begin
            r_t0 <= a;
            r_t1 <= b;
            r_t2 <= c;
        end
        if (wr_here && i_ctl.kind == tuc_pkg::KIND_QUAD) begin
            r_q0 <= a;
            r_q1 <= b;
            r_q2 <= c;
            r_q3 <= d;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_tup  = r_tup;
    assign o_lod  = r_lod;
    assign o_tot  = r_tot;
    assign o_slot = r_slot;

endmodule

`default_nettype wire

[design/tuple_set_union_merge_core.sv]
// Tuple set union/merge core.
// Input stream (i_s_axis_*): one transaction per command. tdata carries the
// command and four atom indices, tuser the tuple kind (pair, triple, quad).
// Output stream (o_m_axis_*): one transaction per input with status, slot
// and the entry count of the addressed table.
// Each tuple table is spread over a row of ENTRIES cells, one entry per
// cell. A command enters the row as a token and moves one cell per cycle;
// each cell compares it with its own entry and the cell at the table's
// fill position stores it. The row length sets the timing: the token passes
// the injection register and every cell register of the row; its result is
// then captured and loaded into the output register once that register is
// free. One command is in flight at a time; the input is ready again together
// with the result, so a new command is taken only after the last one completes.
// The output register holds a result while the receiver stalls; the next
// command is accepted meanwhile and waits at its end of the row until the
// output register frees up.
// Reset empties all tables (counts go to zero); the table contents are not
// cleared and are never read before being written.
`default_nettype none

module tuple_set_union_merge_core #(
    parameter int ENTRIES   = tuc_pkg::DEF_ENTRIES,
    parameter int ATOM_BITS = tuc_pkg::DEF_ATOM_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [1:0] command, [11:2] atom_a, [21:12] atom_b, [31:22] atom_c,
    // [41:32] atom_d, [47:42] zero
    input  wire  [tuc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] kind
    input  wire  [1:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // [1:0] status, [7:2] slot, [14:8] entry_count, [15] zero
    output logic [tuc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    localparam int AW    = ATOM_BITS;
    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int FW    = tuc_pkg::FLD_ATOM_W;

    tuc_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_lod [0:2];
    logic [CNT_W-1:0] r_tot [0:2];
    logic [CNT_W-1:0] n_lod [0:2];
    logic [CNT_W-1:0] n_tot [0:2];

    logic [1:0]       r_cmd, r_kind;
    logic [CNT_W-1:0] r_kt, r_kl;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;

    tuc_pkg::t_ctl    r_inj_ctl, n_inj_ctl;
    logic [4*AW-1:0]  r_inj_tup;
    logic [CNT_W-1:0] r_inj_lod, r_inj_tot;

    logic                               r_out_valid, n_out_valid;
    logic [1:0]                         r_out_status, n_out_status;
    logic [tuc_pkg::FLD_SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic [tuc_pkg::FLD_COUNT_W-1:0]    r_out_count, n_out_count;

    logic             in_acc;
    logic             out_free;
    logic [1:0]       in_cmd, in_kind;
    logic             in_kind_ok;
    logic [CNT_W-1:0] in_tot, in_lod;
    logic [4*AW-1:0]  in_tup;

    tuc_pkg::t_ctl    w_ctl  [0:ENTRIES];
    logic [4*AW-1:0]  w_tup  [0:ENTRIES];
    logic [CNT_W-1:0] w_lod  [0:ENTRIES];
    logic [CNT_W-1:0] w_tot  [0:ENTRIES];
    logic [IDX_W-1:0] w_slot [0:ENTRIES];
    logic [ENTRIES:0] w_vld;

    assign in_cmd     = i_s_axis_tdata[1:0];
    assign in_kind    = i_s_axis_tuser;
    assign in_kind_ok = (in_kind != tuc_pkg::KIND_NONE);
    assign in_tup     = {AW'(i_s_axis_tdata[2+4*FW-1:2+3*FW]),
                         AW'(i_s_axis_tdata[2+3*FW-1:2+2*FW]),
                         AW'(i_s_axis_tdata[2+2*FW-1:2+FW]),
                         AW'(i_s_axis_tdata[2+FW-1:2])};

    assign o_s_axis_tready = (r_state == tuc_pkg::S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        case (in_kind)
            tuc_pkg::KIND_PAIR: begin
                in_tot = r_tot[0];
                in_lod = r_lod[0];
            end
            tuc_pkg::KIND_TRIPLE: begin
                in_tot = r_tot[1];
                in_lod = r_lod[1];
            end
            tuc_pkg::KIND_QUAD: begin
                in_tot = r_tot[2];
                in_lod = r_lod[2];
            end
            default: begin
                in_tot = '0;
                in_lod = '0;
            end
        endcase
    end

    // token for the head of the cell row
    always_comb begin
        n_inj_ctl       = '0;
        n_inj_ctl.valid = in_acc;
        n_inj_ctl.kind  = in_kind;
        n_inj_ctl.wr    = (in_cmd == tuc_pkg::CMD_LOAD || in_cmd == tuc_pkg::CMD_MERGE) &&
                          in_kind_ok && (in_tot < CNT_W'(ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj_ctl <= '0;
        end else begin
            r_inj_ctl <= n_inj_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_inj_tup <= in_tup;
            r_inj_lod <= (in_cmd == tuc_pkg::CMD_MERGE) ? in_lod : '0;
            r_inj_tot <= in_tot;
            r_cmd     <= in_cmd;
            r_kind    <= in_kind;
            r_kt      <= in_tot;
            r_kl      <= in_lod;
        end
        if (r_state == tuc_pkg::S_BUSY && w_ctl[ENTRIES].valid) begin
            r_found <= w_ctl[ENTRIES].found;
            r_slot  <= w_slot[ENTRIES];
        end
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

    assign w_ctl[0]  = r_inj_ctl;
    assign w_tup[0]  = r_inj_tup;
    assign w_lod[0]  = r_inj_lod;
    assign w_tot[0]  = r_inj_tot;
    assign w_slot[0] = '0;

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            tuc_cell #(
                .ENTRIES   (ENTRIES),
                .ATOM_BITS (ATOM_BITS),
                .IDX       (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k]),
                .i_tup   (w_tup[k]),
                .i_lod   (w_lod[k]),
                .i_tot   (w_tot[k]),
                .i_slot  (w_slot[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_tup   (w_tup[k+1]),
                .o_lod   (w_lod[k+1]),
                .o_tot   (w_tot[k+1]),
                .o_slot  (w_slot[k+1])
            );
        end
        for (k = 0; k <= ENTRIES; k++) begin : g_vld
            assign w_vld[k] = w_ctl[k].valid;
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        for (int j = 0; j < 3; j++) begin
            n_lod[j] = r_lod[j];
            n_tot[j] = r_tot[j];
        end
        case (r_state)
            tuc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = tuc_pkg::S_BUSY;
                end
            end
            tuc_pkg::S_BUSY: begin
                if (w_ctl[ENTRIES].valid) begin
                    n_state = tuc_pkg::S_DONE;
                end
            end
            tuc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state      = tuc_pkg::S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_slot   = '0;
                    n_out_status = tuc_pkg::ST_FULL;
                    n_out_count  = tuc_pkg::FLD_COUNT_W'(r_kt);
                    if (r_cmd == tuc_pkg::CMD_CLEAR) begin
                        n_out_status = tuc_pkg::ST_CLEARED;
                        n_out_count  = '0;
                        for (int j = 0; j < 3; j++) begin
                            n_lod[j] = '0;
                            n_tot[j] = '0;
                        end
                    end else if (r_kind == tuc_pkg::KIND_NONE) begin
                        n_out_count = '0;
                    end else if (r_cmd != tuc_pkg::CMD_LOAD &&
                                 r_cmd != tuc_pkg::CMD_MERGE) begin
                        n_out_status = tuc_pkg::ST_FULL;
                    end else if (r_found) begin
                        n_out_status = tuc_pkg::ST_DUP;
                        n_out_slot   = tuc_pkg::FLD_SLOT_W'(r_slot);
                    end else if (r_kt < CNT_W'(ENTRIES)) begin
                        n_out_status    = tuc_pkg::ST_STORED;
                        n_out_slot      = tuc_pkg::FLD_SLOT_W'(r_kt);
                        n_out_count     = tuc_pkg::FLD_COUNT_W'(r_kt + CNT_W'(1));
                        n_tot[r_kind]   = r_kt + CNT_W'(1);
                        // first set grows only while no merged entry follows it
                        if (r_cmd == tuc_pkg::CMD_LOAD && r_kl == r_kt) begin
                            n_lod[r_kind] = r_kl + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = tuc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tuc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_lod[j] <= '0;
                r_tot[j] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            for (int j = 0; j < 3; j++) begin
                r_lod[j] <= n_lod[j];
                r_tot[j] <= n_tot[j];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_slot, r_out_status};

`ifndef NO_ASSERTIONS
    // at most one token travels the cell row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) <= 1)
        else $error("more than one token in the cell row");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[ENTRIES].valid |-> r_state == tuc_pkg::S_BUSY)
        else $error("token left the row outside BUSY");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lod[0] <= r_tot[0] && r_lod[1] <= r_tot[1] && r_lod[2] <= r_tot[2] &&
        r_tot[0] <= CNT_W'(ENTRIES) && r_tot[1] <= CNT_W'(ENTRIES) &&
        r_tot[2] <= CNT_W'(ENTRIES))
        else $error("table counts out of range");

    a_accept_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_inj_ctl.valid && r_state == tuc_pkg::S_BUSY)
        else $error("accepted command not injected");
`endif

endmodule

`default_nettype wire
